// ===== rtl/mtgc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtgc_pkg
// Types and constants shared by the multi-tap gesture classifier and its
// checker.
// ----------------------------------------------------------------------------
package mtgc_pkg;

   localparam int MAX_TAPS  = 3;
   localparam int COUNT_W   = $clog2(MAX_TAPS + 1);
   localparam int TIME_W    = 48;
   localparam int COORD_W   = 10;
   localparam int DUR_W     = 24;
   localparam int EDGE_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [DUR_W-1:0]  TAP_MAX_RESET     = DUR_W'(400000);
   localparam logic [DUR_W-1:0]  QUIET_RESET       = DUR_W'(350000);
   localparam logic [EDGE_W-1:0] HEAD_LEFT_RESET   = EDGE_W'(0);
   localparam logic [EDGE_W-1:0] HEAD_RIGHT_RESET  = EDGE_W'(240);
   localparam logic [EDGE_W-1:0] HEAD_TOP_RESET    = EDGE_W'(0);
   localparam logic [EDGE_W-1:0] HEAD_BOTTOM_RESET = EDGE_W'(144);

   typedef enum logic [1:0] {
      GESTURE_NONE   = 2'd0,
      GESTURE_SINGLE = 2'd1,
      GESTURE_DOUBLE = 2'd2,
      GESTURE_HEAD   = 2'd3
   } gesture_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_MAX     = 3'd0,
      CSR_QUIET       = 3'd1,
      CSR_HEAD_LEFT   = 3'd2,
      CSR_HEAD_RIGHT  = 3'd3,
      CSR_HEAD_TOP    = 3'd4,
      CSR_HEAD_BOTTOM = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               finger_down;
      logic [COORD_W-1:0] touch_x;
      logic [COORD_W-1:0] touch_y;
      logic [TIME_W-1:0]  time_us;
      logic               suppress;
   } req_type;

   typedef struct packed {
      gesture_type gesture;
      logic [1:0]  pending_taps;
   } rsp_type;

endpackage

// ===== rtl/multi_tap_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// multi_tap_gesture_classifier
// Counts short presses from touch samples and commits single, double or head
// multi-tap gestures after a quiet window.
// ----------------------------------------------------------------------------
// An accepted request passes the input register, then the result register,
// which drives rsp_valid. Throughput: one transaction per cycle unless
// rsp_ready stalls; the input and result registers are each one entry deep.
// Reset: synchronous, active high; clears gesture state, both valid flags and
// restores the configuration registers to their default values.
module multi_tap_gesture_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mtgc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mtgc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mtgc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mtgc_pkg::CSR_DAT_W-1:0]       csr_data
);

   localparam int CW = mtgc_pkg::COUNT_W;
   localparam int TW = mtgc_pkg::TIME_W;
   localparam int EW = mtgc_pkg::EDGE_W;

   // configuration
   logic [mtgc_pkg::DUR_W-1:0] tap_max_ff, quiet_ff;
   logic [EW-1:0]              left_ff, right_ff, top_ff, bottom_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   mtgc_pkg::req_type in_data_ff;

   // gesture state
   logic [TW-1:0] press_time_ff, press_time_in;
   logic          prev_down_ff, prev_down_in;
   logic [CW-1:0] count_ff, count_in;
   logic          head_ff, head_in;
   logic [TW-1:0] deadline_ff, deadline_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   mtgc_pkg::rsp_type out_data_ff, out_data_in;

   logic          advance;
   logic          rise, fall, in_head, is_tap;
   logic [TW-1:0] held;
   logic [CW-1:0] count_tap;
   logic [TW-1:0] deadline_tap;
   logic signed [EW:0] x_s, y_s;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_max_ff <= mtgc_pkg::TAP_MAX_RESET;
         quiet_ff   <= mtgc_pkg::QUIET_RESET;
         left_ff    <= mtgc_pkg::HEAD_LEFT_RESET;
         right_ff   <= mtgc_pkg::HEAD_RIGHT_RESET;
         top_ff     <= mtgc_pkg::HEAD_TOP_RESET;
         bottom_ff  <= mtgc_pkg::HEAD_BOTTOM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mtgc_pkg::CSR_TAP_MAX:     tap_max_ff <= csr_data;
            mtgc_pkg::CSR_QUIET:       quiet_ff   <= csr_data;
            mtgc_pkg::CSR_HEAD_LEFT:   left_ff    <= csr_data[EW-1:0];
            mtgc_pkg::CSR_HEAD_RIGHT:  right_ff   <= csr_data[EW-1:0];
            mtgc_pkg::CSR_HEAD_TOP:    top_ff     <= csr_data[EW-1:0];
            mtgc_pkg::CSR_HEAD_BOTTOM: bottom_ff  <= csr_data[EW-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign x_s = $signed({1'b0, 1'b0, in_data_ff.touch_x});
   assign y_s = $signed({1'b0, 1'b0, in_data_ff.touch_y});

   always_comb begin
      rise    = in_data_ff.finger_down && !prev_down_ff;
      fall    = !in_data_ff.finger_down && prev_down_ff;
      in_head = (x_s >= $signed({left_ff[EW-1], left_ff}))
             && (x_s <  $signed({right_ff[EW-1], right_ff}))
             && (y_s >= $signed({top_ff[EW-1], top_ff}))
             && (y_s <  $signed({bottom_ff[EW-1], bottom_ff}));
      held         = in_data_ff.time_us - press_time_ff;
      is_tap       = fall && (held < TW'(tap_max_ff));
      count_tap    = (count_ff < CW'(mtgc_pkg::MAX_TAPS)) ? count_ff + CW'(1) : count_ff;
      deadline_tap = in_data_ff.time_us + TW'(quiet_ff);

      press_time_in = rise ? in_data_ff.time_us : press_time_ff;
      head_in       = head_ff || (rise && in_head);
      count_in      = is_tap ? count_tap : count_ff;
      deadline_in   = is_tap ? deadline_tap : deadline_ff;
      prev_down_in  = in_data_ff.finger_down;

      out_data_in.gesture = mtgc_pkg::GESTURE_NONE;
      if ((count_in != '0) && (in_data_ff.time_us > deadline_in)) begin
         if (!in_data_ff.suppress) begin
            if ((count_in >= CW'(mtgc_pkg::MAX_TAPS)) && head_in) begin
               out_data_in.gesture = mtgc_pkg::GESTURE_HEAD;
            end else if (count_in >= CW'(2)) begin
               out_data_in.gesture = mtgc_pkg::GESTURE_DOUBLE;
            end else begin
               out_data_in.gesture = mtgc_pkg::GESTURE_SINGLE;
            end
         end
         count_in = '0;
         head_in  = 1'b0;
      end
      out_data_in.pending_taps = (count_in > CW'(3)) ? 2'd3 : count_in[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         press_time_ff <= '0;
         prev_down_ff  <= 1'b0;
         count_ff      <= '0;
         head_ff       <= 1'b0;
         deadline_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            press_time_ff <= press_time_in;
            prev_down_ff  <= prev_down_in;
            count_ff      <= count_in;
            head_ff       <= head_in;
            deadline_ff   <= deadline_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/mtgc_checker.sv =====
// ----------------------------------------------------------------------------
// mtgc_checker
// Port-level checks on the multi-tap gesture classifier, bound to the top.
// ----------------------------------------------------------------------------
module mtgc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mtgc_pkg::rsp_type rsp_data
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_commit_clears : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.gesture != mtgc_pkg::GESTURE_NONE))
         |-> (rsp_data.pending_taps == 2'd0))
      else $error("pending taps left after committed gesture");

   a_flow : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is free");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response transaction changed");

endmodule

bind multi_tap_gesture_classifier mtgc_checker u_mtgc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
